/* hw/rtl/all_pairs_shortest_path_defines.svh */
// Assertion macros shared by the shortest-path RTL.
`ifndef ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define APSP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked out of reset.
`define APSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define APSP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define APSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/apsp_pkg.sv */
// Shared constants and types of the all-pairs shortest path block.
`timescale 1ns / 1ps
package apsp_pkg;

	localparam int MAX_VERTICES_DEF = 8;
	localparam int DIST_W           = 48;
	localparam int WEIGHT_W         = 32;
	localparam int VC_W             = 4;
	localparam int VIDX_W           = 3;

	localparam logic [VC_W-1:0] VC_RESET = 4'd8;

	localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	// One stored distance: infinite mark plus the saturated value.
	typedef struct packed {
		logic                     inf;
		logic signed [DIST_W-1:0] len;
	} dist_entry_t;

	// Outcome of one relaxation step.
	typedef struct packed {
		logic        wr;
		dist_entry_t value;
	} relax_res_t;

	// One request on the result channel.
	typedef struct packed {
		logic signed [DIST_W-1:0] path_length;
		logic                     unreachable;
		logic [VIDX_W-1:0]        source_vertex;
		logic [VIDX_W-1:0]        target_vertex;
		logic                     negative_cycle;
		logic                     final_entry;
	} out_item_t;

endpackage

/* hw/rtl/apsp_if.sv */
// Channel interfaces: configuration, edge input and distance output.
`timescale 1ns / 1ps
interface apsp_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [apsp_pkg::VC_W-1:0]   vertex_count;

	modport source (output valid, output vertex_count, input ready);
	modport sink   (input valid, input vertex_count, output ready);
endinterface

interface apsp_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [apsp_pkg::WEIGHT_W-1:0] edge_weight;
	logic                                no_edge;

	modport source (output valid, output edge_weight, output no_edge, input ready);
	modport sink   (input valid, input edge_weight, input no_edge, output ready);
endinterface

interface apsp_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [apsp_pkg::DIST_W-1:0] path_length;
	logic                              unreachable;
	logic [apsp_pkg::VIDX_W-1:0]       source_vertex;
	logic [apsp_pkg::VIDX_W-1:0]       target_vertex;
	logic                              negative_cycle;
	logic                              final_entry;

	modport source (output valid, output path_length, output unreachable,
		output source_vertex, output target_vertex, output negative_cycle,
		output final_entry, input ready);
	modport sink   (input valid, input path_length, input unreachable,
		input source_vertex, input target_vertex, input negative_cycle,
		input final_entry, output ready);
endinterface

/* hw/rtl/apsp_ram.sv */
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module apsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* hw/rtl/apsp_relax.sv */
// Relaxation step: saturating detour sum and compare against the current distance.
`timescale 1ns / 1ps
module apsp_relax (
	input  apsp_pkg::dist_entry_t ik,
	input  apsp_pkg::dist_entry_t kj,
	input  apsp_pkg::dist_entry_t ij,
	output apsp_pkg::relax_res_t  res
);

	logic [apsp_pkg::DIST_W:0]          sum;
	logic signed [apsp_pkg::DIST_W-1:0] cand;
	logic                               ovf;

	always_comb begin
		sum = {ik.len[apsp_pkg::DIST_W-1], ik.len} + {kj.len[apsp_pkg::DIST_W-1], kj.len};
		ovf = sum[apsp_pkg::DIST_W] != sum[apsp_pkg::DIST_W-1];
		if (ovf) begin
			cand = sum[apsp_pkg::DIST_W] ? apsp_pkg::DIST_MIN : apsp_pkg::DIST_MAX;
		end else begin
			cand = $signed(sum[apsp_pkg::DIST_W-1:0]);
		end
		// skip when the second half of the detour is infinite
		res.wr         = !kj.inf && (ij.inf || ($signed(cand) < $signed(ij.len)));
		res.value.inf  = 1'b0;
		res.value.len  = cand;
	end

endmodule

/* hw/rtl/apsp_out_fifo.sv */
// Two-entry result queue between the distance memory and the output channel.
`timescale 1ns / 1ps
module apsp_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  apsp_pkg::out_item_t push_data,
	input  logic                pop,
	output logic                valid,
	output apsp_pkg::out_item_t head,
	output logic [1:0]          count
);

	apsp_pkg::out_item_t slot_q [2];
	logic                wp_q;
	logic                rp_q;
	logic [1:0]          cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_data;
		end
	end

	assign valid = cnt_q != 2'd0;
	assign head  = slot_q[rp_q];
	assign count = cnt_q;

endmodule

/* hw/rtl/all_pairs_shortest_path.sv */
// Top level of the all-pairs shortest path block (Floyd-Warshall over a stored matrix).
// Channels: cfg writes vertex_count (n, 0 acts as 1, clamped to MAX_VERTICES) and restarts
// loading when taken in the load phase; edges takes n*n requests in row-major order, one per
// cycle while loading; dists returns the n*n distances in row-major order, each with
// source/target indexes, an unreachable flag, the negative-cycle flag and final_entry on the
// last one. After the last edge request, relaxation walks each (k,i) row, k outermost: it
// fetches d[i][k], then runs a read-modify-write pipeline over j on the two read ports;
// a row whose d[i][k] is infinite is skipped. Then the diagonal is scanned, and then one
// distance leaves per cycle while the receiver is ready. Relaxation uses a single lane.
// The edge channel is ready only while loading; it reopens as soon as the last distance
// read has been issued, while up to two results still wait in the output queue.
// Hold an edge request off while a register write is offered, so the two never meet.
// A stalled receiver holds the queue and pauses the distance reads; nothing is dropped.
// Reset: vertex_count returns to 8, loading restarts at entry 0, the queue empties.
// The distance memory is not cleared; every entry that is read was loaded first.
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_defines.svh"
module all_pairs_shortest_path #(
	parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	apsp_cfg_if.sink    cfg,
	apsp_in_if.sink     edges,
	apsp_out_if.source  dists
);

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam logic [6:0] MAXV = 7'(MAX_VERTICES);

	typedef enum logic [6:0] {
		S_LOAD  = 7'b0000001,
		S_IK    = 7'b0000010,
		S_IKW   = 7'b0000100,
		S_ROW   = 7'b0001000,
		S_DRAIN = 7'b0010000,
		S_NEG   = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t                        state_q;
	logic [apsp_pkg::VC_W-1:0]     vc_q;
	logic [VW-1:0]                 i_q;
	logic [VW-1:0]                 j_q;
	logic [VW-1:0]                 k_q;
	logic                          neg_q;
	apsp_pkg::dist_entry_t         ik_q;

	// relaxation pipeline stage
	logic                          row_v_s1;
	logic [VW-1:0]                 j_s1;
	// diagonal scan and emission stages
	logic                          dg_v_s1;
	logic                          rd_v_s1;
	logic [VW-1:0]                 src_s1;
	logic [VW-1:0]                 tgt_s1;
	logic                          fin_s1;

	logic [6:0]                    vc_ext;
	logic [6:0]                    n7;
	logic [VW-1:0]                 nm1;
	logic [VW-1:0]                 ni;
	logic [VW-1:0]                 nk;
	logic                          last_row;
	logic                          done;

	logic                          cfg_fire;
	logic                          in_fire;
	logic                          pop;
	logic                          issue;
	logic [1:0]                    fifo_cnt;
	logic [1:0]                    occ;
	logic                          fifo_valid;
	apsp_pkg::out_item_t           fifo_head;
	apsp_pkg::out_item_t           push_item;
	logic [VW+2:0]                 src_ext;
	logic [VW+2:0]                 tgt_ext;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	apsp_pkg::dist_entry_t         ram_wdata;
	logic                          ram_re_a;
	logic [AW-1:0]                 ram_raddr_a;
	apsp_pkg::dist_entry_t         ram_rdata_a;
	logic                          ram_re_b;
	logic [AW-1:0]                 ram_raddr_b;
	apsp_pkg::dist_entry_t         ram_rdata_b;
	apsp_pkg::dist_entry_t         load_entry;
	apsp_pkg::relax_res_t          rx;

	// Clamp the register: 0 acts as 1, anything above the built size acts as the size.
	always_comb begin
		vc_ext = {3'b000, vc_q};
		if (vc_ext == 7'd0) begin
			n7 = 7'd1;
		end else if (vc_ext > MAXV) begin
			n7 = MAXV;
		end else begin
			n7 = vc_ext;
		end
		nm1 = VW'(n7 - 7'd1);
	end

	// Next (i,k) pair of the relaxation walk, k outermost.
	assign last_row = i_q == nm1;
	assign done     = last_row && (k_q == nm1);
	assign ni       = last_row ? '0 : i_q + VW'(1);
	assign nk       = last_row ? k_q + VW'(1) : k_q;

	assign cfg.ready   = 1'b1;
	assign cfg_fire    = cfg.valid && cfg.ready;
	assign edges.ready = (state_q == S_LOAD) && !cfg.valid;
	assign in_fire     = edges.valid && edges.ready;

	// Issue a distance read only when the queue has room counting the read in flight.
	assign pop   = fifo_valid && dists.ready;
	assign occ   = fifo_cnt + {1'b0, rd_v_s1};
	assign issue = (state_q == S_EMIT) && ((occ < 2'd2) || pop);

	assign load_entry.inf = edges.no_edge;
	assign load_entry.len = {{(apsp_pkg::DIST_W - apsp_pkg::WEIGHT_W)
		{edges.edge_weight[apsp_pkg::WEIGHT_W-1]}}, edges.edge_weight};

	// Memory port steering.
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = {i_q, j_q};
		ram_wdata   = load_entry;
		ram_re_a    = 1'b0;
		ram_raddr_a = {i_q, k_q};
		ram_re_b    = 1'b0;
		ram_raddr_b = {i_q, j_q};
		case (state_q)
			S_LOAD: begin
				ram_we = in_fire;
			end
			S_IK: begin
				ram_re_a = 1'b1;
			end
			S_IKW: begin
				// unreachable d[i][k]: drop the row and fetch the next pivot entry at once
				if (ram_rdata_a.inf && !done) begin
					ram_re_a    = 1'b1;
					ram_raddr_a = {ni, nk};
				end
			end
			S_ROW: begin
				ram_re_a    = 1'b1;
				ram_raddr_a = {k_q, j_q};
				ram_re_b    = 1'b1;
			end
			S_DRAIN: begin
				ram_re_a    = !done;
				ram_raddr_a = {ni, nk};
			end
			S_NEG: begin
				ram_re_b    = 1'b1;
				ram_raddr_b = {i_q, i_q};
			end
			S_EMIT: begin
				ram_re_b = issue;
			end
			default: begin
				ram_re_a = 1'b0;
			end
		endcase
		// write back an improved d[i][j] in the cycle after its reads
		if (row_v_s1 && rx.wr) begin
			ram_we    = 1'b1;
			ram_waddr = {i_q, j_s1};
			ram_wdata = rx.value;
		end
	end

	apsp_ram #(
		.WIDTH ($bits(apsp_pkg::dist_entry_t)),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re_a    (ram_re_a),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.re_b    (ram_re_b),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

	apsp_relax u_relax (
		.ik  (ik_q),
		.kj  (ram_rdata_a),
		.ij  (ram_rdata_b),
		.res (rx)
	);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			vc_q     <= apsp_pkg::VC_RESET;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			neg_q    <= 1'b0;
			row_v_s1 <= 1'b0;
			dg_v_s1  <= 1'b0;
			rd_v_s1  <= 1'b0;
		end else begin
			row_v_s1 <= state_q == S_ROW;
			dg_v_s1  <= state_q == S_NEG;
			rd_v_s1  <= issue;
			if (cfg_fire) begin
				vc_q <= cfg.vertex_count;
			end
			// any finite negative diagonal marks a negative cycle
			if (dg_v_s1 && !ram_rdata_b.inf && ram_rdata_b.len[apsp_pkg::DIST_W-1]) begin
				neg_q <= 1'b1;
			end
			case (state_q)
				S_LOAD: begin
					if (cfg_fire) begin
						i_q <= '0;
						j_q <= '0;
					end else if (in_fire) begin
						if (j_q == nm1) begin
							j_q <= '0;
							if (i_q == nm1) begin
								i_q     <= '0;
								k_q     <= '0;
								neg_q   <= 1'b0;
								state_q <= S_IK;
							end else begin
								i_q <= i_q + VW'(1);
							end
						end else begin
							j_q <= j_q + VW'(1);
						end
					end
				end
				S_IK: begin
					state_q <= S_IKW;
				end
				S_IKW: begin
					if (ram_rdata_a.inf) begin
						if (done) begin
							i_q     <= '0;
							state_q <= S_NEG;
						end else begin
							i_q <= ni;
							k_q <= nk;
						end
					end else begin
						j_q     <= '0;
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					if (j_q == nm1) begin
						state_q <= S_DRAIN;
					end else begin
						j_q <= j_q + VW'(1);
					end
				end
				S_DRAIN: begin
					if (done) begin
						i_q     <= '0;
						state_q <= S_NEG;
					end else begin
						i_q     <= ni;
						k_q     <= nk;
						state_q <= S_IKW;
					end
				end
				S_NEG: begin
					if (i_q == nm1) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						i_q <= i_q + VW'(1);
					end
				end
				S_EMIT: begin
					if (issue) begin
						if (j_q == nm1) begin
							j_q <= '0;
							if (i_q == nm1) begin
								i_q     <= '0;
								state_q <= S_LOAD;
							end else begin
								i_q <= i_q + VW'(1);
							end
						end else begin
							j_q <= j_q + VW'(1);
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Pivot-row entry d[i][k]: load it, then track the write when j reaches k.
	always_ff @(posedge clk) begin
		if (state_q == S_IKW) begin
			ik_q <= ram_rdata_a;
		end else if (row_v_s1 && rx.wr && (j_s1 == k_q)) begin
			ik_q <= rx.value;
		end
		if (state_q == S_ROW) begin
			j_s1 <= j_q;
		end
		if (issue) begin
			src_s1 <= i_q;
			tgt_s1 <= j_q;
			fin_s1 <= (i_q == nm1) && (j_q == nm1);
		end
	end

	// Result formatting: infinite distances read as zero.
	always_comb begin
		src_ext                  = {3'b000, src_s1};
		tgt_ext                  = {3'b000, tgt_s1};
		push_item.path_length    = ram_rdata_b.inf ? '0 : ram_rdata_b.len;
		push_item.unreachable    = ram_rdata_b.inf;
		push_item.source_vertex  = src_ext[apsp_pkg::VIDX_W-1:0];
		push_item.target_vertex  = tgt_ext[apsp_pkg::VIDX_W-1:0];
		push_item.negative_cycle = neg_q;
		push_item.final_entry    = fin_s1;
	end

	apsp_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rd_v_s1),
		.push_data (push_item),
		.pop       (pop),
		.valid     (fifo_valid),
		.head      (fifo_head),
		.count     (fifo_cnt)
	);

	assign dists.valid          = fifo_valid;
	assign dists.path_length    = fifo_head.path_length;
	assign dists.unreachable    = fifo_head.unreachable;
	assign dists.source_vertex  = fifo_head.source_vertex;
	assign dists.target_vertex  = fifo_head.target_vertex;
	assign dists.negative_cycle = fifo_head.negative_cycle;
	assign dists.final_entry    = fifo_head.final_entry;

	// Write-back never lands on an address that a port reads in the same cycle.
	`APSP_ASSERT_IMPL(a_port_a_clash, clk, arst_n, ram_we && ram_re_a, ram_waddr != ram_raddr_a, "write collides with read port A")
	`APSP_ASSERT_IMPL(a_port_b_clash, clk, arst_n, ram_we && ram_re_b, ram_waddr != ram_raddr_b, "write collides with read port B")
	// A read in flight always has a queue slot waiting for it.
	`APSP_ASSERT_IMPL(a_queue_room, clk, arst_n, rd_v_s1, fifo_cnt < 2'd2, "result queue overrun")
	// Rows run only behind a finite pivot entry.
	`APSP_ASSERT_IMPL(a_row_finite, clk, arst_n, state_q == S_ROW, !ik_q.inf, "row relaxed through infinite pivot")
	// A drained row hands over to the next pivot fetch or to the diagonal scan.
	`APSP_ASSERT_NEXT(a_drain_next, clk, arst_n, state_q == S_DRAIN, state_q == S_IKW || state_q == S_NEG, "bad step after row drain")

endmodule

/* tb/sv/apsp_distance_monitor.sv */
// Channel monitor for the shortest-path block: predicts every distance request and compares it.
`timescale 1ns / 1ps
module apsp_distance_monitor (
	input  logic clk,
	input  logic arst_n,
	apsp_cfg_if  cfg,
	apsp_in_if   edges,
	apsp_out_if  dists,
	output int   fail_count,
	output int   distances_owed,
	output int   distances_checked,
	output int   graphs_closed,
	output int   neg_cycle_graphs,
	output int   clamped_sums
);

	localparam int MAXV = apsp_pkg::MAX_VERTICES_DEF;

	logic [apsp_pkg::VC_W-1:0] vertex_count;
	int                        loaded;
	apsp_pkg::dist_entry_t     dist_mat [MAXV*MAXV];
	apsp_pkg::out_item_t       pending_distances [$];

	int fails      = 0;
	int checked    = 0;
	int closed     = 0;
	int neg_graphs = 0;
	int clamps     = 0;

	// Store one edge; on the last entry of the matrix relax it and queue all n*n distances.
	task automatic take_edge(input logic signed [apsp_pkg::WEIGHT_W-1:0] weight,
		input logic absent);
		int n, slot, i, j, k, ik, kj, ij;
		logic signed [apsp_pkg::DIST_W:0]   wide;
		logic signed [apsp_pkg::DIST_W-1:0] cand;
		logic                               neg;
		apsp_pkg::out_item_t                item;
		n = (vertex_count == 0) ? 1 : ((vertex_count > MAXV) ? MAXV : int'(vertex_count));
		if (loaded >= n * n)
			loaded = 0;
		slot = (loaded / n) * MAXV + loaded % n;
		dist_mat[slot].len = apsp_pkg::DIST_W'(weight);
		dist_mat[slot].inf = absent;
		loaded++;
		if (loaded < n * n)
			return;
		loaded = 0;

		// Intermediate vertex outermost; skip any detour with an infinite half.
		for (k = 0; k < n; k++)
			for (i = 0; i < n; i++) begin
				ik = i * MAXV + k;
				if (dist_mat[ik].inf)
					continue;
				for (j = 0; j < n; j++) begin
					kj = k * MAXV + j;
					ij = i * MAXV + j;
					if (dist_mat[kj].inf)
						continue;
					wide = $signed(dist_mat[ik].len) + $signed(dist_mat[kj].len);
					if (wide > apsp_pkg::DIST_MAX) begin
						cand = apsp_pkg::DIST_MAX;
						clamps++;
					end else if (wide < apsp_pkg::DIST_MIN) begin
						cand = apsp_pkg::DIST_MIN;
						clamps++;
					end else begin
						cand = wide[apsp_pkg::DIST_W-1:0];
					end
					if (dist_mat[ij].inf || cand < $signed(dist_mat[ij].len)) begin
						dist_mat[ij].len = cand;
						dist_mat[ij].inf = 1'b0;
					end
				end
			end

		neg = 1'b0;
		for (i = 0; i < n; i++)
			if (!dist_mat[i * MAXV + i].inf && $signed(dist_mat[i * MAXV + i].len) < 0)
				neg = 1'b1;

		for (i = 0; i < n; i++)
			for (j = 0; j < n; j++) begin
				ij                  = i * MAXV + j;
				item.unreachable    = dist_mat[ij].inf;
				item.path_length    = dist_mat[ij].inf ? '0 : dist_mat[ij].len;
				item.source_vertex  = apsp_pkg::VIDX_W'(i);
				item.target_vertex  = apsp_pkg::VIDX_W'(j);
				item.negative_cycle = neg;
				item.final_entry    = (i == n - 1) && (j == n - 1);
				pending_distances.push_back(item);
			end
		closed++;
		if (neg)
			neg_graphs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count = apsp_pkg::VC_RESET;
			loaded       = 0;
			pending_distances.delete();
		end else begin
			if (dists.valid && dists.ready) begin
				if (pending_distances.size() == 0) begin
					$error("distance request %0d -> %0d with none expected",
						dists.source_vertex, dists.target_vertex);
					fails++;
				end else begin
					apsp_pkg::out_item_t want;
					want = pending_distances.pop_front();
					if (dists.path_length !== want.path_length) begin
						$error("path_length expected %0d got %0d", want.path_length,
							dists.path_length);
						fails++;
					end
					if (dists.unreachable !== want.unreachable) begin
						$error("unreachable expected %0d got %0d", want.unreachable,
							dists.unreachable);
						fails++;
					end
					if (dists.source_vertex !== want.source_vertex) begin
						$error("source_vertex expected %0d got %0d", want.source_vertex,
							dists.source_vertex);
						fails++;
					end
					if (dists.target_vertex !== want.target_vertex) begin
						$error("target_vertex expected %0d got %0d", want.target_vertex,
							dists.target_vertex);
						fails++;
					end
					if (dists.negative_cycle !== want.negative_cycle) begin
						$error("negative_cycle expected %0d got %0d", want.negative_cycle,
							dists.negative_cycle);
						fails++;
					end
					if (dists.final_entry !== want.final_entry) begin
						$error("final_entry expected %0d got %0d", want.final_entry,
							dists.final_entry);
						fails++;
					end
					checked++;
				end
			end
			if (cfg.valid && cfg.ready) begin
				vertex_count = cfg.vertex_count;
				loaded       = 0;
			end
			if (edges.valid && edges.ready)
				take_edge(edges.edge_weight, edges.no_edge);
		end
		fail_count        <= fails;
		distances_owed    <= pending_distances.size();
		distances_checked <= checked;
		graphs_closed     <= closed;
		neg_cycle_graphs  <= neg_graphs;
		clamped_sums      <= clamps;
	end

endmodule

/* tb/sv/testbench.sv */
// Top of the shortest-path testbench: clock, reset, edge and register stimulus, verdict.
`timescale 1ns / 1ps
module testbench;

	localparam int MAXV           = apsp_pkg::MAX_VERTICES_DEF;
	localparam int ITEM_TARGET    = 320;   // stop starting new phases past this many edges
	localparam int CALM_FROM      = 260;   // no idling on either side from here on
	localparam int SETTLE_CYCLES  = 10;    // quiet time before a register write
	localparam int DRAIN_CYCLES   = 700;   // about one full relaxation at eight vertices
	localparam int LONG_HOLD      = 1200;  // receiver hold-off during the pressure phase
	localparam int WATCHDOG_LIMIT = 20000;

	// Flavors of random edge content.
	typedef enum int {W_MIXED, W_FULL, W_DEEP_NEG, W_SPARSE, W_NEAR_MAX} weight_mode_e;

	logic clk;
	logic arst_n;

	apsp_cfg_if cfg_bus();
	apsp_in_if  edge_bus();
	apsp_out_if dist_bus();

	int fail_count;
	int distances_owed;
	int distances_checked;
	int graphs_closed;
	int neg_cycle_graphs;
	int clamped_sums;

	int edges_sent      = 0;
	int sender_idle_pct = 20;
	bit calm            = 1'b0;
	bit pressure_phase  = 1'b0;
	bit pressure_done   = 1'b0;

	all_pairs_shortest_path DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus),
		.edges (edge_bus),
		.dists (dist_bus)
	);

	// The monitor sees the same wires as the block and keeps the score.
	apsp_distance_monitor dist_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_bus),
		.edges            (edge_bus),
		.dists            (dist_bus),
		.fail_count       (fail_count),
		.distances_owed   (distances_owed),
		.distances_checked(distances_checked),
		.graphs_closed    (graphs_closed),
		.neg_cycle_graphs (neg_cycle_graphs),
		.clamped_sums     (clamped_sums)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one edge request; sometimes drop valid first for a random idle burst.
	// Return at the edge where the request was taken, with valid still high.
	task automatic send_edge(input logic signed [apsp_pkg::WEIGHT_W-1:0] weight,
		input logic absent);
		if (!calm && $urandom_range(0, 99) < sender_idle_pct) begin
			edge_bus.valid       <= 1'b0;
			edge_bus.edge_weight <= $urandom();
			edge_bus.no_edge     <= 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		edge_bus.valid       <= 1'b1;
		edge_bus.edge_weight <= weight;
		edge_bus.no_edge     <= absent;
		@(posedge clk);
		while (!edge_bus.ready) @(posedge clk);
		edges_sent++;
	endtask

	// Send count entries of a graph (count below n*n makes a broken, partial load).
	task automatic send_graph(input int count, input weight_mode_e mode);
		logic signed [apsp_pkg::WEIGHT_W-1:0] weight;
		logic                                 absent;
		int                                   e;
		for (e = 0; e < count; e++) begin
			case (mode)
				W_MIXED: begin
					absent = ($urandom_range(0, 99) < 30);
					weight = $urandom_range(0, 60);
					weight = weight - 8;
				end
				W_FULL: begin
					absent = ($urandom_range(0, 9) == 0);
					weight = $urandom();
				end
				W_DEEP_NEG: begin
					// All weights near the bottom: detours compound until they clamp.
					absent = ($urandom_range(0, 19) == 0);
					weight = 32'h8000_0000 + $urandom_range(0, 255);
				end
				W_SPARSE: begin
					absent = ($urandom_range(0, 9) != 0);
					weight = $urandom_range(1, 1000);
				end
				default: begin
					absent = ($urandom_range(0, 3) == 0);
					weight = 32'h7FFF_FFFF - $urandom_range(0, 255);
				end
			endcase
			send_edge(weight, absent);
		end
	endtask

	// Drop valid, wait for the monitor to owe nothing, then hold quiet for SETTLE_CYCLES.
	// The first edge lets the owed count catch up with the last accepted request.
	task automatic wait_until_idle();
		edge_bus.valid <= 1'b0;
		@(posedge clk);
		while (distances_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [apsp_pkg::VC_W-1:0] value);
		wait_until_idle();
		cfg_bus.valid        <= 1'b1;
		cfg_bus.vertex_count <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Receiver: ready in bursts, one long hold-off while the pressure phase runs.
	initial begin : receiver
		int r;
		dist_bus.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (pressure_phase && !pressure_done) begin
				// Hold long enough for a whole graph to load, relax and back up the queue.
				dist_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				pressure_done = 1'b1;
			end else if (!calm && r < 20) begin
				dist_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				dist_bus.ready <= 1'b1;
				repeat ((r >= 95) ? $urandom_range(20, 60) : 1) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run when no request moves on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cfg_bus.valid && cfg_bus.ready) || (edge_bus.valid && edge_bus.ready) ||
					(dist_bus.valid && dist_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		logic [apsp_pkg::VC_W-1:0] vc_plan [10];
		logic [apsp_pkg::VC_W-1:0] vc;
		int                        n, graphs, g, p;

		vc_plan = '{4'd2, 4'd15, 4'd3, 4'd8, 4'd6, 4'd0, 4'd7, 4'd4, 4'd1, 4'd5};

		arst_n               <= 1'b0;
		cfg_bus.valid        <= 1'b0;
		cfg_bus.vertex_count <= apsp_pkg::VC_RESET;
		edge_bus.valid       <= 1'b0;
		edge_bus.edge_weight <= '0;
		edge_bus.no_edge     <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Single vertex: every edge request is a whole graph. Cover both weight extremes,
		// a negative self loop, and an infinite diagonal that must not flag a cycle.
		write_vertex_count(4'd1);
		send_edge(32'sh7FFF_FFFF, 1'b0);
		send_edge(32'sh8000_0000, 1'b0);
		send_edge($urandom(), 1'b1);
		send_edge(32'sd0, 1'b0);
		send_edge(-32'sd1, 1'b0);

		// A count of zero acts as one vertex.
		write_vertex_count(4'd0);
		send_edge(32'sd1, 1'b0);
		send_edge(32'sh8000_0001, 1'b0);

		// Two vertices with a negative loop through both, unreachable second diagonal.
		write_vertex_count(4'd2);
		send_edge(32'sd0, 1'b0);
		send_edge(-32'sd5, 1'b0);
		send_edge(32'sd3, 1'b0);
		send_edge(32'sd9, 1'b1);

		// Partial load, then a register write that restarts loading.
		send_edge(32'sd9, 1'b0);
		send_edge(32'sd2, 1'b1);
		write_vertex_count(4'd3);
		send_edge(32'sd0, 1'b0);
		send_edge(32'sd4, 1'b0);
		send_edge(32'sd0, 1'b1);
		send_edge(32'sd0, 1'b1);
		send_edge(32'sd0, 1'b0);
		send_edge(-32'sd2, 1'b0);
		send_edge(32'sd1, 1'b0);
		send_edge(-32'sd7, 1'b0);
		send_edge(32'sd0, 1'b1);

		// Pressure: keep offering graphs while the receiver holds off, so the block
		// backs up and closes its edge channel.
		write_vertex_count(4'd5);
		pressure_phase  = 1'b1;
		sender_idle_pct = 0;
		for (g = 0; g < 3; g++)
			send_graph(25, weight_mode_e'($urandom_range(0, 4)));

		// Random phases: whole graphs with random content, now and then a broken load.
		p = 0;
		while (edges_sent < ITEM_TARGET) begin
			vc = (p < 10) ? vc_plan[p] : 4'($urandom_range(0, 15));
			p++;
			write_vertex_count(vc);
			n               = (vc == 0) ? 1 : ((vc > MAXV) ? MAXV : int'(vc));
			sender_idle_pct = 15 * $urandom_range(0, 3);
			calm            = (edges_sent >= CALM_FROM);
			graphs          = (n <= 4) ? $urandom_range(2, 4) : 1;
			for (g = 0; g < graphs; g++)
				send_graph(n * n, (vc == 4'd8 && g == 0) ? W_DEEP_NEG :
					weight_mode_e'($urandom_range(0, 4)));
			if (n > 1 && $urandom_range(0, 2) == 0)
				send_graph($urandom_range(1, n * n - 1), weight_mode_e'($urandom_range(0, 4)));
		end

		wait_until_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d edge requests; checked %0d distances over %0d graphs.",
			edges_sent, distances_checked, graphs_closed);
		$display("%0d graphs had a negative cycle; %0d relaxed sums hit the distance range.",
			neg_cycle_graphs, clamped_sums);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/apsp_pkg.sv
hw/rtl/apsp_if.sv
hw/rtl/apsp_ram.sv
hw/rtl/apsp_relax.sv
hw/rtl/apsp_out_fifo.sv
hw/rtl/all_pairs_shortest_path.sv
tb/sv/apsp_distance_monitor.sv
tb/sv/testbench.sv
